>>> hw/rtl/mmt_pkg.sv
// Shared types and constants for the matrix multiply block.
// Used by the channel interfaces, the sequencer, the multiply-accumulate unit
// and the top level. Depends on nothing.
package mmt_pkg;

  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 16;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_M      = 3'd0,
    CFG_COLS_N      = 3'd1,
    CFG_INNER_K     = 3'd2,
    CFG_TRANSPOSE_A = 3'd3,
    CFG_TRANSPOSE_B = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

>>> hw/rtl/mmt_if.sv
// Request and result channel interfaces of the matrix multiply block.
// Depends on mmt_pkg for field widths.
interface mmt_item_if import mmt_pkg::*; #(
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              operation;
  logic [IDX_W-1:0]             row_index;
  logic [IDX_W-1:0]             col_index;
  logic signed [ELEM_WIDTH-1:0] element;

  modport source(output valid, operation, row_index, col_index, element, input ready);
  modport sink(input valid, operation, row_index, col_index, element, output ready);
endinterface

interface mmt_result_if import mmt_pkg::*; #(
  parameter int OUT_WIDTH = 2 * DEF_ELEM_WIDTH + $clog2(DEF_MAX_DIM)
) ();
  logic                        valid;
  logic                        ready;
  logic [IDX_W-1:0]            out_row;
  logic [IDX_W-1:0]            out_col;
  logic signed [OUT_WIDTH-1:0] out_value;
  logic                        last;

  modport source(output valid, out_row, out_col, out_value, last, input ready);
  modport sink(input valid, out_row, out_col, out_value, last, output ready);
endinterface

>>> hw/rtl/matrix_multiply_transpose_core.sv
// Top level of the matrix multiply block with optional operand transposition.
// Depends on mmt_pkg, mmt_if, mmt_ram, mmt_mac and mmt_seq.
//
//   Channel   Direction  Handshake          Contents
//   item      in         valid/ready        operation, row_index, col_index, element
//   result    out        valid/ready        out_row, out_col, out_value, last
//   cfg       in         cfg_we only        cfg_index, cfg_data
//
// A write request is stored in the operand RAM as soon as it is accepted.
// A compute request emits m*n results; for each, the sequencer issues k products
// to the shared multiply-accumulate unit, waits for the RAM read, product and
// accumulate registers, then emits the result when the result channel has room.
// The request channel is not ready while a compute runs.
// Reset is synchronous; the operand stores are not cleared.
// A stalled result holds in the output register and pauses the sequencer.
module matrix_multiply_transpose_core import mmt_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mmt_item_if.sink              item,
  mmt_result_if.source          result
);

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OUT_WIDTH = 2 * ELEM_WIDTH + $clog2(MAX_DIM);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  logic [DIM_W-1:0]             rows_m, cols_n, inner_k;
  logic                         transpose_a, transpose_b;
  logic                         accept, start, in_range, we_a, we_b;
  logic [AW-1:0]                waddr, addr_a, addr_b;
  logic [ELEM_WIDTH-1:0]        rdata_a, rdata_b;
  logic                         busy, done, emit, slot_free, last_elem;
  logic [IDX_W-1:0]             row, col;
  mac_ctl_t                     ctl;
  logic signed [OUT_WIDTH-1:0]  acc;
  logic                         out_valid;
  logic [IDX_W-1:0]             out_row, out_col;
  logic signed [OUT_WIDTH-1:0]  out_value;
  logic                         out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m      <= DIM_W'(8);
      cols_n      <= DIM_W'(8);
      inner_k     <= DIM_W'(8);
      transpose_a <= 1'b0;
      transpose_b <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_M:      rows_m      <= cfg_data[DIM_W-1:0];
        CFG_COLS_N:      cols_n      <= cfg_data[DIM_W-1:0];
        CFG_INNER_K:     inner_k     <= cfg_data[DIM_W-1:0];
        CFG_TRANSPOSE_A: transpose_a <= cfg_data[0];
        CFG_TRANSPOSE_B: transpose_b <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item.ready = !busy;
  assign accept     = item.valid && item.ready;
  assign start      = accept && item.operation == OP_COMPUTE;
  assign in_range   = ({1'b0, item.row_index} < DIM_W'(MAX_DIM))
                   && ({1'b0, item.col_index} < DIM_W'(MAX_DIM));
  assign we_a       = accept && in_range && item.operation == OP_WRITE_A;
  assign we_b       = accept && in_range && item.operation == OP_WRITE_B;
  assign waddr      = AW'(int'(item.row_index) * MAX_DIM + int'(item.col_index));

  mmt_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(item.element),
    .raddr(addr_a),
    .rdata(rdata_a)
  );

  mmt_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(item.element),
    .raddr(addr_b),
    .rdata(rdata_b)
  );

  mmt_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dim_m    (clamp_dim(rows_m)),
    .dim_n    (clamp_dim(cols_n)),
    .dim_k    (clamp_dim(inner_k)),
    .trans_a  (transpose_a),
    .trans_b  (transpose_b),
    .done     (done),
    .slot_free(slot_free),
    .busy     (busy),
    .addr_a   (addr_a),
    .addr_b   (addr_b),
    .ctl      (ctl),
    .emit     (emit),
    .row      (row),
    .col      (col),
    .last_elem(last_elem)
  );

  mmt_mac #(.ELEM_WIDTH(ELEM_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .a   (signed'(rdata_a)),
    .b   (signed'(rdata_b)),
    .acc (acc),
    .done(done)
  );

  assign slot_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row   <= row;
      out_col   <= col;
      out_value <= acc;
      out_last  <= last_elem;
    end
  end

  assign result.valid     = out_valid;
  assign result.out_row   = out_row;
  assign result.out_col   = out_col;
  assign result.out_value = out_value;
  assign result.last      = out_last;

endmodule

>>> hw/rtl/mmt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds one operand matrix. Depends on nothing.
module mmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mmt_mac.sv
// Shared multiply-accumulate unit: a registered product followed by an accumulator.
// Depends on mmt_pkg for the control struct.
module mmt_mac import mmt_pkg::*; #(
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int OUT_WIDTH  = 2 * DEF_ELEM_WIDTH + $clog2(DEF_MAX_DIM)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mac_ctl_t                     ctl,
  input  logic signed [ELEM_WIDTH-1:0] a,
  input  logic signed [ELEM_WIDTH-1:0] b,
  output logic signed [OUT_WIDTH-1:0]  acc,
  output logic                         done
);

  mac_ctl_t                       ctl_prod;
  logic signed [2*ELEM_WIDTH-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_prod <= '0;
      done     <= 1'b0;
    end else begin
      ctl_prod <= ctl;
      done     <= ctl_prod.valid && ctl_prod.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctl_prod.valid) begin
      acc <= ctl_prod.first ? OUT_WIDTH'(prod) : acc + OUT_WIDTH'(prod);
    end
  end

endmodule

>>> hw/rtl/mmt_seq.sv
// Sequencer that walks the result matrix and the inner dimension, drives the
// operand store addresses and tags each product for the accumulator. Depends on mmt_pkg.
module mmt_seq import mmt_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIM_W-1:0] dim_m,
  input  logic [DIM_W-1:0] dim_n,
  input  logic [DIM_W-1:0] dim_k,
  input  logic             trans_a,
  input  logic             trans_b,
  input  logic             done,
  input  logic             slot_free,
  output logic             busy,
  output logic [AW-1:0]    addr_a,
  output logic [AW-1:0]    addr_b,
  output mac_ctl_t         ctl,
  output logic             emit,
  output logic [IDX_W-1:0] row,
  output logic [IDX_W-1:0] col,
  output logic             last_elem
);

  seq_state_t       state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] p, p_next;
  logic [DIM_W-1:0] m_q, n_q, k_q;
  logic             ta_q, tb_q;
  logic             i_last, j_last, p_last;

  assign i_last    = DIM_W'(i) == m_q - DIM_W'(1);
  assign j_last    = DIM_W'(j) == n_q - DIM_W'(1);
  assign p_last    = DIM_W'(p) == k_q - DIM_W'(1);
  assign last_elem = i_last && j_last;
  assign busy      = state != S_IDLE;
  assign row       = i;
  assign col       = j;

  assign addr_a = ta_q ? AW'(int'(p) * MAX_DIM + int'(i)) : AW'(int'(i) * MAX_DIM + int'(p));
  assign addr_b = tb_q ? AW'(int'(j) * MAX_DIM + int'(p)) : AW'(int'(p) * MAX_DIM + int'(j));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctl   <= '0;
    end else begin
      state     <= state_next;
      ctl.valid <= state == S_ISSUE;
      ctl.first <= p == '0;
      ctl.last  <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
    p <= p_next;
    if (start && state == S_IDLE) begin
      m_q  <= dim_m;
      n_q  <= dim_n;
      k_q  <= dim_k;
      ta_q <= trans_a;
      tb_q <= trans_b;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    p_next     = p;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_ISSUE;
          i_next     = '0;
          j_next     = '0;
          p_next     = '0;
        end
      end
      S_ISSUE: begin
        if (p_last) begin
          state_next = S_DRAIN;
        end else begin
          p_next = p + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit   = 1'b1;
          p_next = '0;
          if (last_elem) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_ISSUE;
            if (j_last) begin
              j_next = '0;
              i_next = i + IDX_W'(1);
            end else begin
              j_next = j + IDX_W'(1);
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("Compute request started while the sequencer was busy.");

  a_done_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_DRAIN)
    else $error("Accumulator finished outside the drain wait.");

  a_p_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |-> DIM_W'(p) < k_q)
    else $error("Inner index ran past the inner dimension.");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free && last_elem) |=> state == S_IDLE)
    else $error("Sequencer did not return to idle after the final element.");
`endif

endmodule

>>> bench/tb_matrix_multiply_transpose_core.sv
// Self-checking bench for matrix_multiply_transpose_core: operand writes and compute
// requests go in on the request channel and each result is checked against a predicted GEMM.
// Depends on mmt_pkg, the mmt_item_if and mmt_result_if interfaces, and the core RTL.
module tb_matrix_multiply_transpose_core;
  import mmt_pkg::*;

  localparam int VALUE_W = 2 * DEF_ELEM_WIDTH + $clog2(DEF_MAX_DIM);
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic [DEF_ELEM_WIDTH-1:0] elem;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic               last;
  } c_elem_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mmt_item_if   item_ch ();
  mmt_result_if result_ch ();

  matrix_multiply_transpose_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  logic signed [DEF_ELEM_WIDTH-1:0] mat_a [DEF_MAX_DIM][DEF_MAX_DIM];
  logic signed [DEF_ELEM_WIDTH-1:0] mat_b [DEF_MAX_DIM][DEF_MAX_DIM];
  bit                               a_written [DEF_MAX_DIM][DEF_MAX_DIM];
  bit                               b_written [DEF_MAX_DIM][DEF_MAX_DIM];
  logic [DIM_W-1:0]                 shape_m = 4'd8;
  logic [DIM_W-1:0]                 shape_n = 4'd8;
  logic [DIM_W-1:0]                 shape_k = 4'd8;
  logic                             trans_a = 1'b0;
  logic                             trans_b = 1'b0;

  request_t pending_reqs [$];
  c_elem_t  expected_c [$];
  request_t next_req;
  request_t seen_req;
  c_elem_t  want;

  int  n_pushed = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  gap_max = 0;
  int  stall_max = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  req_taken = 1'b0;
  bit  res_taken = 1'b0;

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(d);
  endfunction

  function automatic logic [DEF_ELEM_WIDTH-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(9, 15));
    if (r == 2) return 4'd8;
    return 4'($urandom_range(1, 4));
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    n_errors++;
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             what, n_checked, got, exp_val);
  endtask

  // Applies one accepted request to the shadow stores; a compute request
  // queues every element of op(A) * op(B) in row-major order.
  task automatic gemm_apply(request_t r);
    int      m;
    int      n;
    int      k;
    longint  acc;
    longint  a;
    longint  b;
    c_elem_t e;
    case (r.op)
      OP_WRITE_A: mat_a[r.row][r.col] = r.elem;
      OP_WRITE_B: mat_b[r.row][r.col] = r.elem;
      OP_COMPUTE: begin
        m = eff_dim(shape_m);
        n = eff_dim(shape_n);
        k = eff_dim(shape_k);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int p = 0; p < k; p++) begin
              a = trans_a ? mat_a[p][i] : mat_a[i][p];
              b = trans_b ? mat_b[j][p] : mat_b[p][j];
              acc += a * b;
            end
            e.row = i[IDX_W-1:0];
            e.col = j[IDX_W-1:0];
            e.value = acc[VALUE_W-1:0];
            e.last = (i == m - 1) && (j == n - 1);
            expected_c = {expected_c, e};
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_req(logic [OP_W-1:0] op, int row, int col,
                          logic [DEF_ELEM_WIDTH-1:0] elem);
    request_t r;
    r.op = op;
    r.row = row[IDX_W-1:0];
    r.col = col[IDX_W-1:0];
    r.elem = elem;
    pending_reqs = {pending_reqs, r};
    n_pushed++;
    if (op == OP_WRITE_A) a_written[row][col] = 1'b1;
    if (op == OP_WRITE_B) b_written[row][col] = 1'b1;
  endtask

  task automatic fill_entry(logic [OP_W-1:0] op, int row, int col);
    if (op == OP_WRITE_A && !a_written[row][col]) begin
      push_req(op, row, col, pick_elem());
    end else if (op == OP_WRITE_B && !b_written[row][col]) begin
      push_req(op, row, col, pick_elem());
    end
  endtask

  // Every operand entry inside the current shape is written before a compute.
  task automatic push_compute();
    int m;
    int n;
    int k;
    m = eff_dim(shape_m);
    n = eff_dim(shape_n);
    k = eff_dim(shape_k);
    for (int i = 0; i < m; i++) begin
      for (int p = 0; p < k; p++) begin
        if (trans_a) fill_entry(OP_WRITE_A, p, i);
        else fill_entry(OP_WRITE_A, i, p);
      end
    end
    for (int j = 0; j < n; j++) begin
      for (int p = 0; p < k; p++) begin
        if (trans_b) fill_entry(OP_WRITE_B, j, p);
        else fill_entry(OP_WRITE_B, p, j);
      end
    end
    push_req(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
  endtask

  task automatic random_request();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 44) begin
      push_req(OP_WRITE_A, $urandom_range(0, 7), $urandom_range(0, 7), pick_elem());
    end else if (sel < 88) begin
      push_req(OP_WRITE_B, $urandom_range(0, 7), $urandom_range(0, 7), pick_elem());
    end else if (sel < 93) begin
      push_req(OP_RESERVED, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
    end else begin
      push_compute();
    end
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ROWS_M:      shape_m = val;
      CFG_COLS_N:      shape_n = val;
      CFG_INNER_K:     shape_k = val;
      CFG_TRANSPOSE_A: trans_a = val[0];
      CFG_TRANSPOSE_B: trans_b = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_shape(logic [DIM_W-1:0] m, logic [DIM_W-1:0] n,
                           logic [DIM_W-1:0] k, logic ta, logic tb);
    write_cfg(CFG_ROWS_M, m);
    write_cfg(CFG_COLS_N, n);
    write_cfg(CFG_INNER_K, k);
    write_cfg(CFG_TRANSPOSE_A, {3'd0, ta});
    write_cfg(CFG_TRANSPOSE_B, {3'd0, tb});
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_pushed || expected_c.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        item_ch.operation <= next_req.op;
        item_ch.row_index <= next_req.row;
        item_ch.col_index <= next_req.col;
        item_ch.element <= next_req.elem;
        item_ch.valid <= 1'b1;
        gap_left = $urandom_range(0, gap_max);
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (res_taken) stall_left = $urandom_range(0, stall_max);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    req_taken = !rst && item_ch.valid && item_ch.ready;
    res_taken = !rst && result_ch.valid && result_ch.ready;
    if (res_taken) begin
      if (expected_c.size() == 0) begin
        report_mismatch("unexpected result value", $signed(result_ch.out_value), 0);
      end else begin
        want = expected_c.pop_front();
        if (result_ch.out_row !== want.row)
          report_mismatch("out_row", result_ch.out_row, want.row);
        if (result_ch.out_col !== want.col)
          report_mismatch("out_col", result_ch.out_col, want.col);
        if (result_ch.out_value !== want.value)
          report_mismatch("out_value", $signed(result_ch.out_value), $signed(want.value));
        if (result_ch.last !== want.last)
          report_mismatch("last", result_ch.last, want.last);
      end
      n_checked++;
    end
    if (req_taken) begin
      seen_req.op = item_ch.operation;
      seen_req.row = item_ch.row_index;
      seen_req.col = item_ch.col_index;
      seen_req.elem = item_ch.element;
      gemm_apply(seen_req);
      n_accepted++;
    end
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.operation = '0;
    item_ch.row_index = '0;
    item_ch.col_index = '0;
    item_ch.element = '0;
    result_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Largest possible sum first, then a reserved request that must not touch A.
    set_shape(4'd1, 4'd1, 4'd8, 1'b0, 1'b0);
    gap_max = 0;
    stall_max = 13;
    for (int p = 0; p < DEF_MAX_DIM; p++) push_req(OP_WRITE_A, 0, p, 16'h8000);
    for (int p = 0; p < DEF_MAX_DIM; p++) push_req(OP_WRITE_B, p, 0, 16'h8000);
    push_req(OP_RESERVED, 0, 0, 16'h5555);
    push_compute();
    push_req(OP_WRITE_A, 0, 0, 16'h7fff);
    push_req(OP_WRITE_B, 7, 7, 16'hffff);
    push_compute();
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_shape(4'd8, 4'd8, 4'd8, 1'b1, 1'b1);
        1: set_shape(4'd0, 4'd15, 4'd0, 1'b0, 1'b1);
        2: set_shape(4'd9, 4'd0, 4'd15, 1'b1, 1'b0);
        default: set_shape(pick_dim(), pick_dim(), pick_dim(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
      stall_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
      repeat (8) random_request();
      push_compute();
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
